FILE: rtl/cpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants for the clock page replacement block
// Field widths, the capacity reset value and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cpr_pkg;

	// Field widths fixed by the interface.
	localparam int PAGE_W = 32;
	localparam int CAP_W  = 5;
	localparam int SLOT_W = 4;
	localparam int CNT_W  = 32;

	// Largest capacity the register can express.
	localparam int MAX_CAP = (1 << CAP_W) - 1;

	// Capacity after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;   // input transfer: latch page, bring hand into range
		logic lookup;  // compare page against resident slots
		logic sweep;   // clear reference bit under hand and advance
		logic update;  // commit the access and load the result register
	} cpr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic match;       // page is resident in a slot in use
		logic fill_free;   // not full and hand is on a free slot
		logic ref_at_hand; // reference bit under hand is set
	} cpr_sts_t;

endpackage

FILE: rtl/cpr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_ctrl: sequencing controller for the clock page replacement block
// Walks each reference through lookup, an optional clock sweep and a commit,
// and owns the input stall and the result valid flag.
// ----------------------------------------------------------------------------
module cpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  cpr_pkg::cpr_sts_t sts,
	output cpr_pkg::cpr_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LOOKUP = 2'd1;
	localparam logic [1:0] ST_SWEEP  = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       in_xfer;

	// New items are taken only between references.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Next state and datapath commands.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.start  = in_xfer;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				if (sts.match || sts.fill_free) begin
					state_d = ST_UPDATE;
				end else begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sts.ref_at_hand) begin
					cmd.sweep = 1'b1;
				end else begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (out_free) begin
					cmd.update = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid: set on commit, cleared when the result is transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// A commit never overwrites a result that is still held by the receiver.
	a_commit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> !(out_valid_q && out_stall))
		else $error("commit while result register is held");

	// A committed reference is visible as a valid result next cycle.
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> out_valid_q)
		else $error("commit did not raise result valid");

	// An accepted reference always proceeds to lookup.
	a_accept_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_LOOKUP))
		else $error("accepted reference skipped lookup");

endmodule

FILE: rtl/cpr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_dp: datapath of the clock page replacement block
// Holds the slot pages, valid and reference bits, the hand, occupancy, the
// saturating totals, the capacity register and the result register.
// ----------------------------------------------------------------------------
module cpr_dp #(
	parameter int SLOTS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic        [cpr_pkg::CAP_W-1:0]  cfg_wdata,
	input  logic signed [cpr_pkg::PAGE_W-1:0] page,
	input  cpr_pkg::cpr_cmd_t                cmd,
	output cpr_pkg::cpr_sts_t                sts,
	output logic                             hit,
	output logic        [cpr_pkg::SLOT_W-1:0] slot,
	output logic                             evicted,
	output logic signed [cpr_pkg::PAGE_W-1:0] evicted_page,
	output logic        [cpr_pkg::CNT_W-1:0]  hit_total,
	output logic        [cpr_pkg::CNT_W-1:0]  miss_total
);

	// Only slots below the largest capacity can ever be in use.
	localparam int DEPTH = (SLOTS < cpr_pkg::MAX_CAP) ? SLOTS : cpr_pkg::MAX_CAP;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [cpr_pkg::CAP_W-1:0] DEPTH_C = cpr_pkg::CAP_W'(DEPTH);

	logic [cpr_pkg::CAP_W-1:0]  cap_q;
	logic [cpr_pkg::CAP_W-1:0]  cap_eff;
	logic [cpr_pkg::PAGE_W-1:0] page_q;
	logic [cpr_pkg::PAGE_W-1:0] slot_page_q [DEPTH];
	logic [DEPTH-1:0]           valid_q;
	logic [DEPTH-1:0]           ref_q;
	logic [IDX_W-1:0]           hand_q;
	logic [IDX_W-1:0]           hand_next;
	logic [cpr_pkg::CAP_W-1:0]  occ_q;
	logic [cpr_pkg::CNT_W-1:0]  hits_q;
	logic [cpr_pkg::CNT_W-1:0]  misses_q;
	logic                       hit_q;
	logic [IDX_W-1:0]           where_q;
	logic [DEPTH-1:0]           match_vec;
	logic                       match_any;
	logic [IDX_W-1:0]           match_idx;
	logic [IDX_W-1:0]           wr_idx;
	logic                       res_hit_q;
	logic [cpr_pkg::SLOT_W-1:0] res_slot_q;
	logic                       res_evicted_q;
	logic [cpr_pkg::PAGE_W-1:0] res_ev_page_q;

	// Capacity in use: zero acts as one, values above the storage clamp.
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = cpr_pkg::CAP_W'(1);
		end else if (cap_q > DEPTH_C) begin
			cap_eff = DEPTH_C;
		end else begin
			cap_eff = cap_q;
		end
	end

	// Parallel tag compare over the slots in use, lowest match wins.
	always_comb begin
		match_any = 1'b0;
		match_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			match_vec[i] = valid_q[i] && (cpr_pkg::CAP_W'(i) < cap_eff)
				&& (slot_page_q[i] == page_q);
		end
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				match_any = 1'b1;
				match_idx = IDX_W'(i);
			end
		end
	end

	// Hand advance with wrap at the capacity.
	always_comb begin
		if ((cpr_pkg::CAP_W'(hand_q) + cpr_pkg::CAP_W'(1)) >= cap_eff) begin
			hand_next = '0;
		end else begin
			hand_next = hand_q + IDX_W'(1);
		end
	end

	// Slot written on commit: the hit slot, or the slot under the hand on a miss.
	assign wr_idx = hit_q ? where_q : hand_q;

	// Status toward the controller.
	assign sts.match       = match_any;
	assign sts.fill_free   = (occ_q < cap_eff) && !valid_q[hand_q];
	assign sts.ref_at_hand = ref_q[hand_q];

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cpr_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Page latch and lookup result.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			page_q <= page;
		end
		if (cmd.lookup) begin
			hit_q   <= match_any;
			where_q <= match_idx;
		end
	end

	// Slot page storage, written only when a miss commits.
	always_ff @(posedge clk) begin
		if (cmd.update && !hit_q) begin
			slot_page_q[wr_idx] <= page_q;
		end
	end

	// Replacement state: valid and reference bits, hand, occupancy, totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			ref_q    <= '0;
			hand_q   <= '0;
			occ_q    <= '0;
			hits_q   <= '0;
			misses_q <= '0;
		end else begin
			if (cmd.start && (cpr_pkg::CAP_W'(hand_q) >= cap_eff)) begin
				hand_q <= '0;
			end
			if (cmd.sweep) begin
				ref_q[hand_q] <= 1'b0;
				hand_q        <= hand_next;
			end
			if (cmd.update) begin
				ref_q[wr_idx] <= 1'b1;
				if (hit_q) begin
					if (hits_q != '1) begin
						hits_q <= hits_q + cpr_pkg::CNT_W'(1);
					end
				end else begin
					if (!valid_q[wr_idx]) begin
						valid_q[wr_idx] <= 1'b1;
						occ_q           <= occ_q + cpr_pkg::CAP_W'(1);
					end
					hand_q <= hand_next;
					if (misses_q != '1) begin
						misses_q <= misses_q + cpr_pkg::CNT_W'(1);
					end
				end
			end
		end
	end

	// Result register, loaded on commit.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_hit_q     <= hit_q;
			res_slot_q    <= cpr_pkg::SLOT_W'(wr_idx);
			res_evicted_q <= !hit_q && valid_q[wr_idx];
			if (!hit_q && valid_q[wr_idx]) begin
				res_ev_page_q <= slot_page_q[wr_idx];
			end else begin
				res_ev_page_q <= '0;
			end
		end
	end

	assign hit          = res_hit_q;
	assign slot         = res_slot_q;
	assign evicted      = res_evicted_q;
	assign evicted_page = res_ev_page_q;
	assign hit_total    = hits_q;
	assign miss_total   = misses_q;

	// Occupancy always equals the number of valid slots.
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) == $countones(valid_q))
		else $error("occupancy out of step with valid bits");

	// The hand lies inside the capacity whenever a lookup runs.
	a_hand_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lookup |-> (cpr_pkg::CAP_W'(hand_q) < cap_eff))
		else $error("hand beyond capacity at lookup");

	// A sweep step only ever clears a set reference bit.
	a_sweep_ref: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> ref_q[hand_q])
		else $error("sweep step on a clear reference bit");

endmodule

FILE: rtl/clock_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_page_replacement: clock (second chance) page replacement cache
// Looks up one page reference per transfer and reports hit or miss, the slot,
// any evicted page and saturating hit and miss totals.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, page) takes one page reference per
//   transfer; the output channel (out_valid, out_stall and the result fields)
//   gives exactly one result per reference, in order.
//   cfg_we with cfg_wdata writes the capacity (slots in use); write it only
//   while no reference is in flight.
//   A reference is taken on transfer, compared against every resident slot
//   in the next cycle, then committed. A hit or a miss that fills a free slot
//   goes from lookup straight to commit; a miss that runs the clock sweep
//   first clears set reference bits under the hand, one slot per cycle, until
//   the hand finds a clear one, then commits. A new reference is taken the
//   cycle after the previous one commits.
//   The result register parts the two sides: while the receiver stalls, the
//   next reference is still taken and processed up to its commit, which
//   waits until the held result has been transferred.
//   Reset empties the cache, clears the totals and sets the capacity to 16.
// ----------------------------------------------------------------------------
module clock_page_replacement #(
	parameter int SLOTS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic        [cpr_pkg::CAP_W-1:0]  cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [cpr_pkg::PAGE_W-1:0] page,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             hit,
	output logic        [cpr_pkg::SLOT_W-1:0] slot,
	output logic                             evicted,
	output logic signed [cpr_pkg::PAGE_W-1:0] evicted_page,
	output logic        [cpr_pkg::CNT_W-1:0]  hit_total,
	output logic        [cpr_pkg::CNT_W-1:0]  miss_total
);

	cpr_pkg::cpr_cmd_t cmd;
	cpr_pkg::cpr_sts_t sts;

	// Sequencing controller.
	cpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Cache state and result datapath.
	cpr_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.page         (page),
		.cmd          (cmd),
		.sts          (sts),
		.hit          (hit),
		.slot         (slot),
		.evicted      (evicted),
		.evicted_page (evicted_page),
		.hit_total    (hit_total),
		.miss_total   (miss_total)
	);

endmodule
